>>> sv/idct_pkg.sv
// Shared types, constants and the butterfly micro-program for the 8x8 inverse DCT.
`default_nettype none

package idct_pkg;

    // Fixed-point constants of the Chen-Wang butterfly.
    localparam int K1 = 2841;
    localparam int K2 = 2676;
    localparam int K3 = 2408;
    localparam int K5 = 1609;
    localparam int K6 = 1108;
    localparam int K7 = 565;
    localparam int KR = 181;

    // Width of the working registers; every intermediate of both passes fits.
    localparam int ACC_W = 40;
    localparam int K_W   = 14;
    localparam int NUM_STEPS = 29;

    // Working register indexes.
    localparam logic [3:0] R_A0 = 4'd0;
    localparam logic [3:0] R_A1 = 4'd1;
    localparam logic [3:0] R_A2 = 4'd2;
    localparam logic [3:0] R_A3 = 4'd3;
    localparam logic [3:0] R_A4 = 4'd4;
    localparam logic [3:0] R_A5 = 4'd5;
    localparam logic [3:0] R_A6 = 4'd6;
    localparam logic [3:0] R_A7 = 4'd7;
    localparam logic [3:0] R_T  = 4'd8;
    localparam int NUM_REGS = 9;

    // Destinations: working registers, then the eight results.
    localparam logic [4:0] D_OUT0 = 5'd9;

    typedef struct packed {
        logic signed [11:0] coef_0;
        logic signed [11:0] coef_1;
        logic signed [11:0] coef_2;
        logic signed [11:0] coef_3;
        logic signed [11:0] coef_4;
        logic signed [11:0] coef_5;
        logic signed [11:0] coef_6;
        logic signed [11:0] coef_7;
    } coef_row_t;

    typedef struct packed {
        logic [7:0] pixel_0;
        logic [7:0] pixel_1;
        logic [7:0] pixel_2;
        logic [7:0] pixel_3;
        logic [7:0] pixel_4;
        logic [7:0] pixel_5;
        logic [7:0] pixel_6;
        logic [7:0] pixel_7;
        logic       last_row;
    } pix_row_t;

    typedef logic signed [15:0] samp_t;
    typedef samp_t [7:0] samp_vec_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef acc_t [7:0] acc_vec_t;

    typedef struct packed {
        logic start;
        logic col_mode;
    } core_ctrl_t;

    typedef enum logic [1:0] {BI_NONE, BI_MID, BI_RND} bias_t;
    typedef enum logic [1:0] {SH_NONE, SH_MID, SH_RND8, SH_FINAL} shift_t;

    // One micro-operation: dst = ((a +/- b) * k + d + bias) >>> shift.
    typedef struct packed {
        logic [3:0]            a;
        logic [3:0]            b;
        logic                  b_en;
        logic                  b_neg;
        logic signed [K_W-1:0] k;
        logic [3:0]            d;
        logic                  d_en;
        bias_t                 bias;
        shift_t                shift;
        logic [4:0]            dst;
    } uop_t;

    function automatic uop_t mk(input logic [3:0] a, input logic [3:0] b, input logic b_en,
                                input logic b_neg, input int k, input logic [3:0] d,
                                input logic d_en, input bias_t bias, input shift_t shift,
                                input logic [4:0] dst);
        uop_t u;
        u.a = a; u.b = b; u.b_en = b_en; u.b_neg = b_neg;
        u.k = K_W'(k);
        u.d = d; u.d_en = d_en; u.bias = bias; u.shift = shift; u.dst = dst;
        return u;
    endfunction

    function automatic uop_t uop_rom(input logic [4:0] step);
        uop_t u;
        case (step)
            5'd0:  u = mk(R_A4, R_A5, 1'b1, 1'b0, K7, R_T, 1'b0, BI_MID, SH_NONE, 5'(R_T));
            5'd1:  u = mk(R_A4, R_A5, 1'b0, 1'b0, K1 - K7, R_T, 1'b1, BI_NONE, SH_MID, 5'(R_A4));
            5'd2:  u = mk(R_A5, R_A5, 1'b0, 1'b0, -(K1 + K7), R_T, 1'b1, BI_NONE, SH_MID,
                          5'(R_A5));
            5'd3:  u = mk(R_A6, R_A7, 1'b1, 1'b0, K3, R_T, 1'b0, BI_MID, SH_NONE, 5'(R_T));
            5'd4:  u = mk(R_A6, R_A6, 1'b0, 1'b0, -(K3 - K5), R_T, 1'b1, BI_NONE, SH_MID,
                          5'(R_A6));
            5'd5:  u = mk(R_A7, R_A7, 1'b0, 1'b0, -(K3 + K5), R_T, 1'b1, BI_NONE, SH_MID,
                          5'(R_A7));
            5'd6:  u = mk(R_A0, R_A1, 1'b1, 1'b0, 1, R_T, 1'b0, BI_NONE, SH_NONE, 5'(R_T));
            5'd7:  u = mk(R_A0, R_A1, 1'b1, 1'b1, 1, R_T, 1'b0, BI_NONE, SH_NONE, 5'(R_A0));
            5'd8:  u = mk(R_A3, R_A2, 1'b1, 1'b0, K6, R_T, 1'b0, BI_MID, SH_NONE, 5'(R_A1));
            5'd9:  u = mk(R_A2, R_A2, 1'b0, 1'b0, -(K2 + K6), R_A1, 1'b1, BI_NONE, SH_MID,
                          5'(R_A2));
            5'd10: u = mk(R_A3, R_A3, 1'b0, 1'b0, K2 - K6, R_A1, 1'b1, BI_NONE, SH_MID,
                          5'(R_A3));
            5'd11: u = mk(R_A4, R_A6, 1'b1, 1'b0, 1, R_T, 1'b0, BI_NONE, SH_NONE, 5'(R_A1));
            5'd12: u = mk(R_A4, R_A6, 1'b1, 1'b1, 1, R_T, 1'b0, BI_NONE, SH_NONE, 5'(R_A4));
            5'd13: u = mk(R_A5, R_A7, 1'b1, 1'b0, 1, R_T, 1'b0, BI_NONE, SH_NONE, 5'(R_A6));
            5'd14: u = mk(R_A5, R_A7, 1'b1, 1'b1, 1, R_T, 1'b0, BI_NONE, SH_NONE, 5'(R_A5));
            5'd15: u = mk(R_T, R_A3, 1'b1, 1'b0, 1, R_T, 1'b0, BI_NONE, SH_NONE, 5'(R_A7));
            5'd16: u = mk(R_T, R_A3, 1'b1, 1'b1, 1, R_T, 1'b0, BI_NONE, SH_NONE, 5'(R_T));
            5'd17: u = mk(R_A0, R_A2, 1'b1, 1'b0, 1, R_T, 1'b0, BI_NONE, SH_NONE, 5'(R_A3));
            5'd18: u = mk(R_A0, R_A2, 1'b1, 1'b1, 1, R_T, 1'b0, BI_NONE, SH_NONE, 5'(R_A0));
            5'd19: u = mk(R_A4, R_A5, 1'b1, 1'b0, KR, R_T, 1'b0, BI_RND, SH_RND8, 5'(R_A2));
            5'd20: u = mk(R_A4, R_A5, 1'b1, 1'b1, KR, R_T, 1'b0, BI_RND, SH_RND8, 5'(R_A4));
            5'd21: u = mk(R_A7, R_A1, 1'b1, 1'b0, 1, R_T, 1'b0, BI_NONE, SH_FINAL, D_OUT0);
            5'd22: u = mk(R_A3, R_A2, 1'b1, 1'b0, 1, R_T, 1'b0, BI_NONE, SH_FINAL,
                          D_OUT0 + 5'd1);
            5'd23: u = mk(R_A0, R_A4, 1'b1, 1'b0, 1, R_T, 1'b0, BI_NONE, SH_FINAL,
                          D_OUT0 + 5'd2);
            5'd24: u = mk(R_T, R_A6, 1'b1, 1'b0, 1, R_T, 1'b0, BI_NONE, SH_FINAL,
                          D_OUT0 + 5'd3);
            5'd25: u = mk(R_T, R_A6, 1'b1, 1'b1, 1, R_T, 1'b0, BI_NONE, SH_FINAL,
                          D_OUT0 + 5'd4);
            5'd26: u = mk(R_A0, R_A4, 1'b1, 1'b1, 1, R_T, 1'b0, BI_NONE, SH_FINAL,
                          D_OUT0 + 5'd5);
            5'd27: u = mk(R_A3, R_A2, 1'b1, 1'b1, 1, R_T, 1'b0, BI_NONE, SH_FINAL,
                          D_OUT0 + 5'd6);
            5'd28: u = mk(R_A7, R_A1, 1'b1, 1'b1, 1, R_T, 1'b0, BI_NONE, SH_FINAL,
                          D_OUT0 + 5'd7);
            default: u = mk(R_T, R_T, 1'b0, 1'b0, 1, R_T, 1'b0, BI_NONE, SH_NONE, 5'(R_T));
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

>>> sv/idct_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module idct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/idct_core.sv
// One-dimensional 8-point butterfly built around a single shared multiply-add unit.
`default_nettype none

module idct_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire idct_pkg::core_ctrl_t  ctrl,
    input  wire idct_pkg::samp_vec_t   x,
    output      logic                  done,
    output      idct_pkg::acc_vec_t    y
);
    import idct_pkg::*;

    acc_t       r_reg [NUM_REGS];
    acc_vec_t   y_reg;
    logic [4:0] step_reg;
    logic       busy_reg;
    logic       mode_reg;
    logic       done_reg;

    uop_t                        u;
    acc_t                        av;
    acc_t                        bv;
    acc_t                        dv;
    logic signed [ACC_W:0]       sum;
    logic signed [ACC_W+K_W:0]   prod;
    logic signed [ACC_W+K_W+1:0] total;
    logic signed [ACC_W+K_W+1:0] shifted;
    logic signed [15:0]          bias_val;
    logic [3:0]                  sh;
    acc_t                        res;
    logic [3:0]                  load_sh;
    acc_t                        load_bias;

    always_comb
    begin
        u   = uop_rom(step_reg);
        av  = r_reg[u.a];
        bv  = u.b_en ? r_reg[u.b] : '0;
        dv  = u.d_en ? r_reg[u.d] : '0;
        sum = u.b_neg ? ((ACC_W+1)'(av) - (ACC_W+1)'(bv)) : ((ACC_W+1)'(av) + (ACC_W+1)'(bv));
        prod = sum * u.k;
        case (u.bias)
            BI_NONE: bias_val = 16'sd0;
            BI_MID:  bias_val = mode_reg ? 16'sd4 : 16'sd0;
            BI_RND:  bias_val = 16'sd128;
            default: bias_val = 16'sd0;
        endcase
        case (u.shift)
            SH_NONE:  sh = 4'd0;
            SH_MID:   sh = mode_reg ? 4'd3 : 4'd0;
            SH_RND8:  sh = 4'd8;
            SH_FINAL: sh = mode_reg ? 4'd14 : 4'd8;
            default:  sh = 4'd0;
        endcase
        total   = (ACC_W+K_W+2)'(prod) + (ACC_W+K_W+2)'(dv) + (ACC_W+K_W+2)'(bias_val);
        shifted = total >>> sh;
        res     = shifted[ACC_W-1:0];
        load_sh   = ctrl.col_mode ? 4'd8 : 4'd11;
        load_bias = ctrl.col_mode ? acc_t'(8192) : acc_t'(128);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            mode_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                mode_reg <= ctrl.col_mode;
            end
            else if (busy_reg)
            begin
                if (step_reg == 5'(NUM_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 5'd1;
            end
        end
    end

    // Operand and result registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            r_reg[R_A0] <= (acc_t'(x[0]) <<< load_sh) + load_bias;
            r_reg[R_A1] <= acc_t'(x[4]) <<< load_sh;
            r_reg[R_A2] <= acc_t'(x[6]);
            r_reg[R_A3] <= acc_t'(x[2]);
            r_reg[R_A4] <= acc_t'(x[1]);
            r_reg[R_A5] <= acc_t'(x[7]);
            r_reg[R_A6] <= acc_t'(x[5]);
            r_reg[R_A7] <= acc_t'(x[3]);
        end
        else if (busy_reg)
        begin
            if (u.dst < D_OUT0)
            begin
                r_reg[u.dst[3:0]] <= res;
            end
            else
            begin
                y_reg[3'(u.dst - D_OUT0)] <= res;
            end
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !busy_reg)
        else $error("core started while busy");
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && $past(step_reg) == 5'(NUM_STEPS - 1))
        else $error("done without last step");
    a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done while still busy");

endmodule

`default_nettype wire

>>> sv/inverse_dct_8x8_top.sv
// Top level of the 8x8 inverse DCT: row store, column sequencing and pixel output.
`default_nettype none

// Channel   Direction  Payload      Handshake
// coef      in         coef_row_t   coef_valid / coef_stall
// pix       out        pix_row_t    pix_valid  / pix_stall
//
// A coefficient row transaction runs the butterfly micro-program in the shared multiply-add
// unit; once the sequencer sees the unit finish, the eight row results are written into the
// 64-entry store, and the next row can be accepted only after that write.
// After the eighth row each of the eight columns is read from the store (one port), run
// through the butterfly and handed over to the pixel buffer, column by column.
// The eight pixel rows then go out one per cycle when unstalled, and the input reopens
// once the last of them has been taken from the output register.
// Reset clears the sequencer, the row counter and the output valid; the store needs none.
// pix_stall only holds the output register; coef_stall is high whenever the block is busy.
module inverse_dct_8x8_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 coef_valid,
    output      logic                 coef_stall,
    input  wire idct_pkg::coef_row_t  coef,
    output      logic                 pix_valid,
    input  wire logic                 pix_stall,
    output      idct_pkg::pix_row_t   pix
);
    import idct_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_ROW, S_ROW_WR, S_COL_RD, S_COL, S_EMIT} state_t;

    state_t     state_reg;
    logic [2:0] row_cnt_reg;
    logic [2:0] wr_idx_reg;
    logic [2:0] col_reg;
    logic [3:0] rd_reg;
    logic [3:0] emit_reg;
    logic       pix_valid_reg;
    pix_row_t   pix_reg;
    samp_vec_t  v_reg;
    logic [7:0][7:0] pixbuf_reg [8];

    core_ctrl_t ctrl;
    samp_vec_t  core_x;
    logic       core_done;
    acc_vec_t   core_y;

    logic        ram_we;
    logic [5:0]  ram_waddr;
    logic [15:0] ram_wdata;
    logic [5:0]  ram_raddr;
    logic [15:0] ram_rdata;

    logic coef_accept;

    // Clip a column result to the pixel range.
    function automatic logic [7:0] sat8(input acc_t val);
        logic [7:0] o;
        if (val < 0)
        begin
            o = 8'd0;
        end
        else if (val > acc_t'(255))
        begin
            o = 8'd255;
        end
        else
        begin
            o = val[7:0];
        end
        return o;
    endfunction

    assign coef_stall  = (state_reg != S_IDLE);
    assign coef_accept = coef_valid && !coef_stall;

    always_comb
    begin
        ctrl.start    = coef_accept || (state_reg == S_COL_RD && rd_reg == 4'd9);
        ctrl.col_mode = (state_reg == S_COL_RD);
        if (state_reg == S_COL_RD)
        begin
            core_x = v_reg;
        end
        else
        begin
            core_x[0] = samp_t'(coef.coef_0);
            core_x[1] = samp_t'(coef.coef_1);
            core_x[2] = samp_t'(coef.coef_2);
            core_x[3] = samp_t'(coef.coef_3);
            core_x[4] = samp_t'(coef.coef_4);
            core_x[5] = samp_t'(coef.coef_5);
            core_x[6] = samp_t'(coef.coef_6);
            core_x[7] = samp_t'(coef.coef_7);
        end
        // Row results wrap to 16 bits as they enter the store.
        ram_we    = (state_reg == S_ROW_WR);
        ram_waddr = {row_cnt_reg, wr_idx_reg};
        ram_wdata = core_y[wr_idx_reg][15:0];
        ram_raddr = {rd_reg[2:0], col_reg};
    end

    idct_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .x     (core_x),
        .done  (core_done),
        .y     (core_y)
    );

    idct_ram #(
        .WIDTH (16),
        .DEPTH (64)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_cnt_reg   <= '0;
            wr_idx_reg    <= '0;
            col_reg       <= '0;
            rd_reg        <= '0;
            emit_reg      <= '0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (coef_accept)
                    begin
                        state_reg <= S_ROW;
                    end
                end
                S_ROW:
                begin
                    if (core_done)
                    begin
                        wr_idx_reg <= '0;
                        state_reg  <= S_ROW_WR;
                    end
                end
                S_ROW_WR:
                begin
                    wr_idx_reg <= wr_idx_reg + 3'd1;
                    if (wr_idx_reg == 3'd7)
                    begin
                        row_cnt_reg <= row_cnt_reg + 3'd1;
                        if (row_cnt_reg == 3'd7)
                        begin
                            col_reg   <= '0;
                            rd_reg    <= '0;
                            state_reg <= S_COL_RD;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_COL_RD:
                begin
                    rd_reg <= rd_reg + 4'd1;
                    if (rd_reg == 4'd9)
                    begin
                        state_reg <= S_COL;
                    end
                end
                S_COL:
                begin
                    if (core_done)
                    begin
                        col_reg <= col_reg + 3'd1;
                        rd_reg  <= '0;
                        if (col_reg == 3'd7)
                        begin
                            emit_reg  <= '0;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_COL_RD;
                        end
                    end
                end
                S_EMIT:
                begin
                    // The output register refills as soon as its transaction completes.
                    if (!pix_valid_reg || !pix_stall)
                    begin
                        if (emit_reg == 4'd8)
                        begin
                            pix_valid_reg <= 1'b0;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            pix_valid_reg <= 1'b1;
                            emit_reg      <= emit_reg + 4'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers: column samples, pixel buffer and the output row.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_COL_RD && rd_reg != 4'd0 && rd_reg <= 4'd8)
        begin
            v_reg[3'(rd_reg - 4'd1)] <= samp_t'(ram_rdata);
        end
        if (state_reg == S_COL && core_done)
        begin
            for (int k = 0; k < 8; k++)
            begin
                pixbuf_reg[k][col_reg] <= sat8(core_y[k]);
            end
        end
        if (state_reg == S_EMIT && (!pix_valid_reg || !pix_stall) && emit_reg != 4'd8)
        begin
            pix_reg.pixel_0  <= pixbuf_reg[emit_reg[2:0]][0];
            pix_reg.pixel_1  <= pixbuf_reg[emit_reg[2:0]][1];
            pix_reg.pixel_2  <= pixbuf_reg[emit_reg[2:0]][2];
            pix_reg.pixel_3  <= pixbuf_reg[emit_reg[2:0]][3];
            pix_reg.pixel_4  <= pixbuf_reg[emit_reg[2:0]][4];
            pix_reg.pixel_5  <= pixbuf_reg[emit_reg[2:0]][5];
            pix_reg.pixel_6  <= pixbuf_reg[emit_reg[2:0]][6];
            pix_reg.pixel_7  <= pixbuf_reg[emit_reg[2:0]][7];
            pix_reg.last_row <= (emit_reg == 4'd7);
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !coef_stall |-> !pix_valid)
        else $error("input open while pixel rows are pending");
    a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix.last_row |-> emit_reg == 4'd8)
        else $error("last_row flagged before the eighth row");
    a_block_to_cols: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROW_WR && wr_idx_reg == 3'd7 && row_cnt_reg == 3'd7
        |=> state_reg == S_COL_RD && row_cnt_reg == 3'd0)
        else $error("eighth row did not start the column pass");
    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        core_done |-> state_reg == S_ROW || state_reg == S_COL)
        else $error("butterfly finished outside a compute state");

endmodule

`default_nettype wire
